// ===== hw/rtl/cps_pkg.sv =====
// Shared types and constants of the cascaded position/speed PID core.
package cps_pkg;

  // Field widths
  localparam int unsigned POS_W     = 32;  // position, targets and setpoint
  localparam int unsigned SPEED_W   = 16;  // measured speed
  localparam int unsigned DRIVE_W   = 16;  // clamped drive command
  localparam int unsigned GAIN_W    = 24;  // unsigned gain registers
  localparam int unsigned ERR_W     = 33;  // raw error, target minus measurement
  localparam int unsigned ERRC_W    = 15;  // clamped error kept for the derivative
  localparam int unsigned DIFF_W    = 16;  // derivative difference

  // Shared multiplier: operands are split into a 24-bit low chunk and a signed high chunk
  localparam int unsigned LO_W      = 24;
  localparam int unsigned CHUNK_W   = 25;
  localparam int unsigned PROD_W    = 2 * CHUNK_W;
  localparam int unsigned MUL_STEPS = 6;   // three products, two chunks each
  localparam int unsigned CNT_W     = 3;

  // Control law constants
  localparam int ERR_BAND  = 100;
  localparam int ERR_CLAMP = 10000;
  localparam int DRIVE_MAX = 20000;

  // Configuration register indexes
  localparam int unsigned REG_IDX_W = 3;
  localparam logic [REG_IDX_W-1:0] REG_POS_KP = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_POS_KI = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_POS_KD = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_SPD_KP = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_SPD_KI = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_SPD_KD = 3'd5;

  // Gain values after reset
  localparam logic [GAIN_W-1:0] POS_KP_RST = 24'd65536;
  localparam logic [GAIN_W-1:0] POS_KI_RST = 24'd0;
  localparam logic [GAIN_W-1:0] POS_KD_RST = 24'd0;
  localparam logic [GAIN_W-1:0] SPD_KP_RST = 24'd655360;
  localparam logic [GAIN_W-1:0] SPD_KI_RST = 24'd52429;
  localparam logic [GAIN_W-1:0] SPD_KD_RST = 24'd327680;

  // Operand feeding the shared multiplier
  typedef enum logic [1:0] {
    OPD_ERR   = 2'd0,
    OPD_INTEG = 2'd1,
    OPD_DIFF  = 2'd2
  } opd_e;

  // Controller to datapath
  typedef struct packed {
    logic accept;    // input transfer this cycle
    logic loop_pos;  // 1: position loop, 0: speed loop
    logic prep;      // form error, update integral and previous error, clear accumulator
    logic mul_en;    // launch one partial product
    logic acc_en;    // add the registered partial product
    opd_e opd;       // operand of the partial product
    logic hi_chunk;  // high chunk of the operand
    logic finish;    // store position loop output as setpoint
    logic out_load;  // load the result register
  } cps_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic target_nz;  // incoming position target is nonzero
  } cps_sts_t;

endpackage

// ===== hw/rtl/cps_if.sv =====
// Valid/ready channel interfaces for input items and result items.
interface cps_in_if import cps_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [POS_W-1:0]   position_target;
  logic signed [POS_W-1:0]   position;
  logic signed [SPEED_W-1:0] speed;
  logic signed [POS_W-1:0]   direct_speed_target;
  logic                      load_speed_target;

  modport source (
    output valid, position_target, position, speed, direct_speed_target,
           load_speed_target,
    input  ready
  );
  modport sink (
    input  valid, position_target, position, speed, direct_speed_target,
           load_speed_target,
    output ready
  );
endinterface

interface cps_out_if import cps_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [DRIVE_W-1:0] drive;
  logic signed [POS_W-1:0]   speed_setpoint;
  logic                      position_loop_ran;

  modport source (
    output valid, drive, speed_setpoint, position_loop_ran,
    input  ready
  );
  modport sink (
    input  valid, drive, speed_setpoint, position_loop_ran,
    output ready
  );
endinterface

// ===== hw/rtl/cps_ctrl.sv =====
// Sequencer of the cascaded PID core: steps each loop through the shared multiplier.
module cps_ctrl import cps_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  input  cps_sts_t sts_i,
  output cps_cmd_t cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_PREP = 4'b0010,
    ST_MUL  = 4'b0100,
    ST_FIN  = 4'b1000
  } state_e;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             loop_pos_q, loop_pos_d;
  logic             out_valid_q, out_valid_d;
  logic             slot_free;

  assign slot_free   = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;

  // Next state and command decode
  always_comb begin
    state_d       = state_q;
    cnt_d         = cnt_q;
    loop_pos_d    = loop_pos_q;
    out_valid_d   = out_valid_q && !out_ready_i;
    in_ready_o    = 1'b0;
    cmd_o          = '0;
    cmd_o.loop_pos = loop_pos_q;
    cmd_o.hi_chunk = cnt_q[0];
    case (cnt_q[2:1])
      2'd0:    cmd_o.opd = OPD_ERR;
      2'd1:    cmd_o.opd = OPD_INTEG;
      default: cmd_o.opd = OPD_DIFF;
    endcase

    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          loop_pos_d   = sts_i.target_nz;
          state_d      = ST_PREP;
        end
      end
      ST_PREP: begin
        cmd_o.prep = 1'b1;
        cnt_d      = '0;
        state_d    = ST_MUL;
      end
      ST_MUL: begin
        // Launch a product on each of the first steps, add it in the cycle after its launch
        cmd_o.mul_en = (cnt_q != CNT_W'(MUL_STEPS));
        cmd_o.acc_en = (cnt_q != '0);
        if (cnt_q == CNT_W'(MUL_STEPS)) begin
          state_d = ST_FIN;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_FIN: begin
        if (loop_pos_q) begin
          // Position result becomes the setpoint, then run the speed loop
          cmd_o.finish = 1'b1;
          loop_pos_d   = 1'b0;
          state_d      = ST_PREP;
        end else if (slot_free) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      loop_pos_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      loop_pos_q  <= loop_pos_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== hw/rtl/cps_dp.sv =====
// Datapath of the cascaded PID core: gains, loop state, shared multiplier, accumulator.
module cps_dp import cps_pkg::*; #(
  parameter int unsigned GAIN_FRAC_BITS = 16,
  parameter int unsigned INTEGRAL_WIDTH = 40
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  cps_cmd_t                    cmd_i,
  output cps_sts_t                    sts_o,
  input  logic signed [POS_W-1:0]     position_target_i,
  input  logic signed [POS_W-1:0]     position_i,
  input  logic signed [SPEED_W-1:0]   speed_i,
  input  logic signed [POS_W-1:0]     direct_speed_target_i,
  input  logic                        load_speed_target_i,
  input  logic                        cfg_we_i,
  input  logic [REG_IDX_W-1:0]        cfg_idx_i,
  input  logic [GAIN_W-1:0]           cfg_data_i,
  output logic signed [DRIVE_W-1:0]   drive_o,
  output logic signed [POS_W-1:0]     speed_setpoint_o,
  output logic                        position_loop_ran_o
);

  localparam int unsigned IW    = INTEGRAL_WIDTH;
  localparam int unsigned OP_W  = (IW > ERR_W) ? IW : ERR_W;
  localparam int unsigned SUM_W = OP_W + 1;
  localparam int unsigned ACC_W = OP_W + GAIN_W + 3;
  localparam int unsigned Q_W   = ACC_W - GAIN_FRAC_BITS;

  localparam logic signed [SUM_W-1:0]  IMAX   = {{(SUM_W-IW+1){1'b0}}, {(IW-1){1'b1}}};
  localparam logic signed [SUM_W-1:0]  IMIN   = ~IMAX;
  localparam logic signed [ERR_W-1:0]  BAND_P = ERR_W'(ERR_BAND);
  localparam logic signed [ERR_W-1:0]  BAND_N = -BAND_P;
  localparam logic signed [ERR_W-1:0]  CLMP_P = ERR_W'(ERR_CLAMP);
  localparam logic signed [ERR_W-1:0]  CLMP_N = -CLMP_P;
  localparam logic signed [Q_W-1:0]    SP_MAX = {{(Q_W-POS_W+1){1'b0}}, {(POS_W-1){1'b1}}};
  localparam logic signed [Q_W-1:0]    SP_MIN = ~SP_MAX;
  localparam logic signed [Q_W-1:0]    DRV_HI = Q_W'(DRIVE_MAX);
  localparam logic signed [Q_W-1:0]    DRV_LO = -DRV_HI;

  // Gain registers
  logic [GAIN_W-1:0] pos_kp_q, pos_ki_q, pos_kd_q, spd_kp_q, spd_ki_q, spd_kd_q;

  // Loop state
  logic signed [IW-1:0]     pos_integ_q, spd_integ_q;
  logic signed [ERRC_W-1:0] pos_prev_q, spd_prev_q;
  logic signed [POS_W-1:0]  held_q;

  // Latched item and working registers
  logic signed [POS_W-1:0]   ptarget_q, position_q;
  logic signed [SPEED_W-1:0] speed_q;
  logic                      ran_q;
  logic signed [ERR_W-1:0]   err_q;
  logic signed [DIFF_W-1:0]  diff_q;
  logic signed [PROD_W-1:0]  prod_q;
  logic                      prod_hi_q;
  logic signed [ACC_W-1:0]   acc_q;
  logic signed [DRIVE_W-1:0] drive_q;
  logic signed [POS_W-1:0]   setpoint_q;
  logic                      ran_out_q;

  // Loop update signals
  logic signed [ERR_W-1:0]  tgt_e, meas_e, err;
  logic signed [IW-1:0]     integ_cur, integ_new;
  logic signed [SUM_W-1:0]  integ_sum, integ_clamp;
  logic                     band_out, band_in;
  logic signed [ERRC_W-1:0] prev_cur, ec;
  logic signed [DIFF_W-1:0] diff;

  // Multiply and accumulate signals
  logic signed [OP_W-1:0]    op_full;
  logic [GAIN_W-1:0]         gain;
  logic signed [CHUNK_W-1:0] gain_s, chunk;
  logic signed [PROD_W-1:0]  mul_res;
  logic signed [ACC_W-1:0]   prod_ext, addend, bias, rnd;
  logic signed [Q_W-1:0]     q, sp_clamp, drv_clamp;

  logic target_nz;

  assign target_nz       = (position_target_i != '0);
  assign sts_o.target_nz = target_nz;

  // Error, integral and derivative terms of the selected loop
  always_comb begin
    tgt_e     = cmd_i.loop_pos ? ERR_W'(ptarget_q) : ERR_W'(held_q);
    meas_e    = cmd_i.loop_pos ? ERR_W'(position_q) : ERR_W'(speed_q);
    err       = tgt_e - meas_e;
    integ_cur = cmd_i.loop_pos ? pos_integ_q : spd_integ_q;
    prev_cur  = cmd_i.loop_pos ? pos_prev_q : spd_prev_q;

    integ_sum = SUM_W'(integ_cur) + SUM_W'(err);
    if (integ_sum > IMAX) begin
      integ_clamp = IMAX;
    end else if (integ_sum < IMIN) begin
      integ_clamp = IMIN;
    end else begin
      integ_clamp = integ_sum;
    end

    // Add outside the band, clear inside it, hold on its edge
    band_out = (err > BAND_P) || (err < BAND_N);
    band_in  = (err < BAND_P) && (err > BAND_N);
    if (band_out) begin
      integ_new = integ_clamp[IW-1:0];
    end else if (band_in) begin
      integ_new = '0;
    end else begin
      integ_new = integ_cur;
    end

    if (err > CLMP_P) begin
      ec = CLMP_P[ERRC_W-1:0];
    end else if (err < CLMP_N) begin
      ec = CLMP_N[ERRC_W-1:0];
    end else begin
      ec = err[ERRC_W-1:0];
    end
    diff = DIFF_W'(ec) - DIFF_W'(prev_cur);
  end

  // Operand and gain of the current partial product
  always_comb begin
    case (cmd_i.opd)
      OPD_ERR: begin
        op_full = OP_W'(err_q);
        gain    = cmd_i.loop_pos ? pos_kp_q : spd_kp_q;
      end
      OPD_INTEG: begin
        op_full = cmd_i.loop_pos ? OP_W'(pos_integ_q) : OP_W'(spd_integ_q);
        gain    = cmd_i.loop_pos ? pos_ki_q : spd_ki_q;
      end
      OPD_DIFF: begin
        op_full = OP_W'(diff_q);
        gain    = cmd_i.loop_pos ? pos_kd_q : spd_kd_q;
      end
      default: begin
        op_full = '0;
        gain    = '0;
      end
    endcase
    gain_s  = signed'({{(CHUNK_W-GAIN_W){1'b0}}, gain});
    chunk   = cmd_i.hi_chunk ? CHUNK_W'(signed'(op_full[OP_W-1:LO_W]))
                             : signed'({{(CHUNK_W-LO_W){1'b0}}, op_full[LO_W-1:0]});
    mul_res = gain_s * chunk;
  end

  // Weight the high-chunk product and round the sum toward zero
  always_comb begin
    prod_ext = ACC_W'(prod_q);
    addend   = prod_hi_q ? (prod_ext <<< LO_W) : prod_ext;
    bias     = signed'({{(ACC_W-GAIN_FRAC_BITS){1'b0}}, {GAIN_FRAC_BITS{acc_q[ACC_W-1]}}});
    rnd      = acc_q + bias;
    q        = signed'(rnd[ACC_W-1:GAIN_FRAC_BITS]);

    if (q > SP_MAX) begin
      sp_clamp = SP_MAX;
    end else if (q < SP_MIN) begin
      sp_clamp = SP_MIN;
    end else begin
      sp_clamp = q;
    end

    if (q > DRV_HI) begin
      drv_clamp = DRV_HI;
    end else if (q < DRV_LO) begin
      drv_clamp = DRV_LO;
    end else begin
      drv_clamp = q;
    end
  end

  // Write gain registers, drop writes beyond the list
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_kp_q <= POS_KP_RST;
      pos_ki_q <= POS_KI_RST;
      pos_kd_q <= POS_KD_RST;
      spd_kp_q <= SPD_KP_RST;
      spd_ki_q <= SPD_KI_RST;
      spd_kd_q <= SPD_KD_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_POS_KP: pos_kp_q <= cfg_data_i;
        REG_POS_KI: pos_ki_q <= cfg_data_i;
        REG_POS_KD: pos_kd_q <= cfg_data_i;
        REG_SPD_KP: spd_kp_q <= cfg_data_i;
        REG_SPD_KI: spd_ki_q <= cfg_data_i;
        REG_SPD_KD: spd_kd_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Advance loop state and the held setpoint
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_integ_q <= '0;
      spd_integ_q <= '0;
      pos_prev_q  <= '0;
      spd_prev_q  <= '0;
      held_q      <= '0;
    end else begin
      if (cmd_i.prep) begin
        if (cmd_i.loop_pos) begin
          pos_integ_q <= integ_new;
          pos_prev_q  <= ec;
        end else begin
          spd_integ_q <= integ_new;
          spd_prev_q  <= ec;
        end
      end
      if (cmd_i.accept && !target_nz && load_speed_target_i) begin
        held_q <= direct_speed_target_i;
      end else if (cmd_i.finish && cmd_i.loop_pos) begin
        held_q <= sp_clamp[POS_W-1:0];
      end
    end
  end

  // Capture the item, run the multiplier and accumulator, load the result
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      ptarget_q  <= position_target_i;
      position_q <= position_i;
      speed_q    <= speed_i;
      ran_q      <= target_nz;
    end
    if (cmd_i.prep) begin
      err_q  <= err;
      diff_q <= diff;
    end
    if (cmd_i.mul_en) begin
      prod_q    <= mul_res;
      prod_hi_q <= cmd_i.hi_chunk;
    end
    if (cmd_i.prep) begin
      acc_q <= '0;
    end else if (cmd_i.acc_en) begin
      acc_q <= acc_q + addend;
    end
    if (cmd_i.out_load) begin
      drive_q    <= drv_clamp[DRIVE_W-1:0];
      setpoint_q <= held_q;
      ran_out_q  <= ran_q;
    end
  end

  assign drive_o             = drive_q;
  assign speed_setpoint_o    = setpoint_q;
  assign position_loop_ran_o = ran_out_q;

endmodule

// ===== hw/rtl/cascaded_position_speed_pid_core.sv =====
// Top level of the cascaded position/speed PID core.
//
//   channel  direction  handshake      payload
//   in_i     sink       valid/ready    position_target, position, speed,
//                                      direct_speed_target, load_speed_target
//   out_o    source     valid/ready    drive, speed_setpoint, position_loop_ran
//   cfg      write      cfg_we_i       cfg_idx_i selects a gain, cfg_data_i
//
// One item at a time through one shared 25x25 multiplier. Each PID loop runs the error
// and integral update, six partial products plus one add, then rounding. An item runs the
// position loop and then the speed loop when its position target is nonzero, else only the
// speed loop. Reset clears gains to their defaults and all loop state to zero.
// A result waiting on out_o does not block the next input transfer; the speed loop
// holds in its final step while the result register is still full.
module cascaded_position_speed_pid_core import cps_pkg::*; #(
  parameter int unsigned GAIN_FRAC_BITS = 16,
  parameter int unsigned INTEGRAL_WIDTH = 40
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  cps_in_if.sink               in_i,
  cps_out_if.source            out_o,
  input  logic                 cfg_we_i,
  input  logic [REG_IDX_W-1:0] cfg_idx_i,
  input  logic [GAIN_W-1:0]    cfg_data_i
);

  cps_cmd_t cmd;
  cps_sts_t sts;

  // Sequencer
  cps_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Datapath
  cps_dp #(
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS),
    .INTEGRAL_WIDTH (INTEGRAL_WIDTH)
  ) u_dp (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cmd_i                 (cmd),
    .sts_o                 (sts),
    .position_target_i     (in_i.position_target),
    .position_i            (in_i.position),
    .speed_i               (in_i.speed),
    .direct_speed_target_i (in_i.direct_speed_target),
    .load_speed_target_i   (in_i.load_speed_target),
    .cfg_we_i              (cfg_we_i),
    .cfg_idx_i             (cfg_idx_i),
    .cfg_data_i            (cfg_data_i),
    .drive_o               (out_o.drive),
    .speed_setpoint_o      (out_o.speed_setpoint),
    .position_loop_ran_o   (out_o.position_loop_ran)
  );

`ifndef ASSERT_OFF
  // No second item is taken right after a transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("input taken while an item is in flight");

  // A new result appears only when the sequencer loads it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_o.valid) |-> $past(cmd.out_load))
    else $error("result valid without a load");

  // Drive stays within its clamp
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> ((out_o.drive <= 16'sd20000) && (out_o.drive >= -16'sd20000)))
    else $error("drive outside clamp");

  // Loop preparation and multiplication never overlap
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd.prep && (cmd.mul_en || cmd.acc_en)))
    else $error("prep overlaps multiply");
`endif

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench of the cascaded position/speed PID core.
`timescale 1ns / 1ps

module testbench import cps_pkg::*;;

  localparam int FRAC_BITS   = 16;
  localparam int INTEG_W     = 40;
  localparam int GAIN_COUNT  = REG_SPD_KD + 1;
  localparam int MAX_WAIT    = 17;
  localparam int DRAIN_TAIL  = 40;
  localparam int CYCLE_LIMIT = 500000;
  localparam int PHASES      = 6;
  localparam int DIR_N       = 20;

  // Write indexes past the last gain register
  localparam logic [REG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  localparam int POS_LOOP = 0;
  localparam int SPD_LOOP = 1;

  localparam logic signed [POS_W-1:0]   S32_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [POS_W-1:0]   S32_MIN = 32'sh8000_0000;
  localparam logic signed [SPEED_W-1:0] S16_MAX = 16'sh7FFF;
  localparam logic signed [SPEED_W-1:0] S16_MIN = 16'sh8000;

  localparam longint          INTEG_MAX  = (longint'(1) << (INTEG_W - 1)) - 1;
  localparam longint          INTEG_MIN  = -INTEG_MAX - 1;
  localparam longint unsigned PROD_LIMIT = 64'd1 << 61;

  typedef struct {
    logic signed [POS_W-1:0]   target;
    logic signed [POS_W-1:0]   position;
    logic signed [SPEED_W-1:0] speed;
    logic signed [POS_W-1:0]   direct;
    logic                      load;
  } tick_t;

  typedef struct {
    logic signed [DRIVE_W-1:0] drive;
    logic signed [POS_W-1:0]   setpoint;
    logic                      ran;
  } drive_cmd_t;

  typedef struct {
    tick_t      stim;
    bit         typed;
    drive_cmd_t want;
  } dir_row_t;

  logic clk;
  logic rst_n;
  logic                 cfg_we;
  logic [REG_IDX_W-1:0] cfg_idx;
  logic [GAIN_W-1:0]    cfg_data;

  cps_in_if  in_ch ();
  cps_out_if out_ch ();

  cascaded_position_speed_pid_core #(
    .GAIN_FRAC_BITS(FRAC_BITS),
    .INTEGRAL_WIDTH(INTEG_W)
  ) dut (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .in_i      (in_ch),
    .out_o     (out_ch),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data)
  );

  // Controller model state
  logic [GAIN_W-1:0]       gain_q [GAIN_COUNT];
  longint                  integ_q [2];
  longint                  prev_err_q [2];
  logic signed [POS_W-1:0] setpoint_q;

  drive_cmd_t predicted_q [$];
  int         fail_count;
  bit         no_gap;
  bit         no_stall;

  // Directed ticks; the typed rows carry results obvious from saturation or all-zero inputs
  dir_row_t dir_rows [DIR_N] = '{
    // idle after reset
    '{'{32'sd0, 32'sd0, 16'sd0, 32'sd0, 1'b0}, 1'b1, '{16'sd0, 32'sd0, 1'b0}},
    // direct load, large positive error
    '{'{32'sd0, 32'sd0, 16'sd0, 32'sd1000000, 1'b1}, 1'b1,
      '{16'sd20000, 32'sd1000000, 1'b0}},
    // most negative setpoint against top speed
    '{'{32'sd0, 32'sd0, S16_MAX, S32_MIN, 1'b1}, 1'b1, '{-16'sd20000, S32_MIN, 1'b0}},
    // load off: direct value ignored
    '{'{32'sd0, 32'sd0, S16_MIN, 32'sd12345, 1'b0}, 1'b1, '{-16'sd20000, S32_MIN, 1'b0}},
    // position output saturates high
    '{'{S32_MAX, S32_MIN, 16'sd0, 32'sd0, 1'b0}, 1'b1, '{16'sd20000, S32_MAX, 1'b1}},
    // position output saturates low, target wins over load
    '{'{S32_MIN, S32_MAX, 16'sd0, 32'sd555, 1'b1}, 1'b1, '{-16'sd20000, S32_MIN, 1'b1}},
    // position loop off keeps its state
    '{'{32'sd0, 32'sd77, 16'sd0, 32'sd999, 1'b0}, 1'b0, '{16'sd0, 32'sd0, 1'b0}},
    '{'{32'sd0, 32'sd0, 16'sd0, 32'sd0, 1'b1}, 1'b0, '{16'sd0, 32'sd0, 1'b0}},
    // position error of exactly plus and minus the band, then zero
    '{'{32'sd100, 32'sd0, 16'sd0, 32'sd0, 1'b0}, 1'b0, '{16'sd0, 32'sd0, 1'b0}},
    '{'{32'sd50, 32'sd150, 16'sd0, 32'sd0, 1'b0}, 1'b0, '{16'sd0, 32'sd0, 1'b0}},
    '{'{32'sd1, 32'sd1, 16'sd0, 32'sd0, 1'b0}, 1'b0, '{16'sd0, 32'sd0, 1'b0}},
    // speed error at the band and just around it
    '{'{32'sd0, 32'sd0, 16'sd0, 32'sd100, 1'b1}, 1'b0, '{16'sd0, 32'sd0, 1'b0}},
    '{'{32'sd0, 32'sd0, 16'sd200, 32'sd0, 1'b0}, 1'b0, '{16'sd0, 32'sd0, 1'b0}},
    '{'{32'sd0, 32'sd0, 16'sd50, 32'sd149, 1'b1}, 1'b0, '{16'sd0, 32'sd0, 1'b0}},
    '{'{32'sd0, 32'sd0, -16'sd51, 32'sd50, 1'b1}, 1'b0, '{16'sd0, 32'sd0, 1'b0}},
    // derivative clamp on both sides
    '{'{32'sd20000, 32'sd0, 16'sd0, 32'sd0, 1'b0}, 1'b0, '{16'sd0, 32'sd0, 1'b0}},
    '{'{-32'sd20000, 32'sd0, 16'sd0, 32'sd0, 1'b0}, 1'b0, '{16'sd0, 32'sd0, 1'b0}},
    // alternating bit patterns, then an all-zero tick
    '{'{32'sh5555_5555, 32'shAAAA_AAAA, 16'sh5555, 32'shAAAA_AAAA, 1'b1}, 1'b0,
      '{16'sd0, 32'sd0, 1'b0}},
    '{'{32'sd0, 32'sh5555_5555, 16'shAAAA, 32'sh5555_5555, 1'b1}, 1'b0,
      '{16'sd0, 32'sd0, 1'b0}},
    '{'{32'sd0, 32'sd0, 16'sd0, 32'sd0, 1'b0}, 1'b0, '{16'sd0, 32'sd0, 1'b0}}
  };

  int phase_items [PHASES] = '{80, 60, 200, 140, 160, 160};

  // Gain times value, magnitude saturated at PROD_LIMIT
  function automatic longint scaled_term(longint v, logic [GAIN_W-1:0] g);
    longint unsigned mag;
    longint unsigned prod;
    longint unsigned gw;
    gw   = longint'(g);
    mag  = (v < 0) ? longint'(-v) : longint'(v);
    if (gw != 0 && mag > PROD_LIMIT / gw) prod = PROD_LIMIT;
    else prod = mag * gw;
    return (v < 0) ? -longint'(prod) : longint'(prod);
  endfunction

  // One PID update of the selected loop; returns the truncated integer output
  function automatic longint pid_update(int lp, longint target, longint meas,
                                        logic [GAIN_W-1:0] kp, logic [GAIN_W-1:0] ki,
                                        logic [GAIN_W-1:0] kd);
    longint err;
    longint abs_err;
    longint nxt;
    longint clamped;
    longint acc;
    longint unsigned mag;
    err     = target - meas;
    abs_err = (err < 0) ? -err : err;
    if (abs_err > ERR_BAND) begin
      nxt = integ_q[lp] + err;
      if (nxt > INTEG_MAX) nxt = INTEG_MAX;
      if (nxt < INTEG_MIN) nxt = INTEG_MIN;
      integ_q[lp] = nxt;
    end else if (abs_err < ERR_BAND) begin
      integ_q[lp] = 0;
    end
    clamped = (err > ERR_CLAMP) ? longint'(ERR_CLAMP) :
              (err < -ERR_CLAMP) ? -longint'(ERR_CLAMP) : err;
    acc = scaled_term(err, kp) + scaled_term(integ_q[lp], ki)
        + scaled_term(clamped - prev_err_q[lp], kd);
    prev_err_q[lp] = clamped;
    if (acc < 0) begin
      mag = longint'(-acc) >> FRAC_BITS;
      return -longint'(mag);
    end
    return acc >>> FRAC_BITS;
  endfunction

  // Advance the controller model by one tick
  function automatic drive_cmd_t predict_control_tick(tick_t t);
    drive_cmd_t r;
    longint     o;
    longint     d;
    r.ran = 1'b0;
    if (t.target != 0) begin
      o = pid_update(POS_LOOP, t.target, t.position, gain_q[REG_POS_KP],
                     gain_q[REG_POS_KI], gain_q[REG_POS_KD]);
      if (o > longint'(S32_MAX)) o = S32_MAX;
      if (o < longint'(S32_MIN)) o = S32_MIN;
      setpoint_q = POS_W'(o);
      r.ran = 1'b1;
    end else if (t.load) begin
      setpoint_q = t.direct;
    end
    d = pid_update(SPD_LOOP, setpoint_q, t.speed, gain_q[REG_SPD_KP],
                   gain_q[REG_SPD_KI], gain_q[REG_SPD_KD]);
    if (d > DRIVE_MAX) d = DRIVE_MAX;
    if (d < -DRIVE_MAX) d = -DRIVE_MAX;
    r.drive    = DRIVE_W'(d);
    r.setpoint = setpoint_q;
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    fail_count++;
    $display("mismatch %s: got %0d expected %0d", what, got, want);
  endtask

  // Present one tick, hold it until the transfer, then record its prediction
  task automatic send_tick(tick_t t, bit typed, drive_cmd_t want);
    int         gap;
    drive_cmd_t pred;
    if ($urandom_range(0, 39) == 0) no_gap = !no_gap;
    gap = no_gap ? 0 : int'($urandom_range(0, MAX_WAIT));
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid               <= 1'b1;
    in_ch.position_target     <= t.target;
    in_ch.position            <= t.position;
    in_ch.speed               <= t.speed;
    in_ch.direct_speed_target <= t.direct;
    in_ch.load_speed_target   <= t.load;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    pred = predict_control_tick(t);
    predicted_q.push_back(typed ? want : pred);
  endtask

  // Drop valid and hold until every predicted result has come back
  task automatic wait_results_done();
    in_ch.valid <= 1'b0;
    while (predicted_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [GAIN_W-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
    if (idx < GAIN_COUNT) gain_q[idx] = data;
  endtask

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Overall time limit
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("status: fail");
    $finish;
  end

  // Result side: random stalls, compare each transfer with the oldest prediction
  initial begin
    int         stall;
    drive_cmd_t want;
    stall = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_ch.valid && out_ch.ready) begin
        if (predicted_q.size() == 0) begin
          report_mismatch("result with nothing pending, drive", out_ch.drive, 0);
        end else begin
          want = predicted_q.pop_front();
          if (out_ch.drive !== want.drive)
            report_mismatch("drive", out_ch.drive, want.drive);
          if (out_ch.speed_setpoint !== want.setpoint)
            report_mismatch("speed_setpoint", out_ch.speed_setpoint, want.setpoint);
          if (out_ch.position_loop_ran !== want.ran)
            report_mismatch("position_loop_ran", out_ch.position_loop_ran, want.ran);
        end
        if ($urandom_range(0, 39) == 0) no_stall = !no_stall;
        stall = no_stall ? 0 : int'($urandom_range(0, MAX_WAIT));
      end
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        stall--;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Stimulus
  initial begin
    tick_t             t;
    drive_cmd_t        none;
    logic [GAIN_W-1:0] new_gain [GAIN_COUNT];
    int                kind;
    int                v;
    int                delta;
    longint            ref_sp;
    longint            s;

    fail_count = 0;
    no_gap     = 1'b0;
    no_stall   = 1'b0;
    none       = '{16'sd0, 32'sd0, 1'b0};

    gain_q[REG_POS_KP] = POS_KP_RST;
    gain_q[REG_POS_KI] = POS_KI_RST;
    gain_q[REG_POS_KD] = POS_KD_RST;
    gain_q[REG_SPD_KP] = SPD_KP_RST;
    gain_q[REG_SPD_KI] = SPD_KI_RST;
    gain_q[REG_SPD_KD] = SPD_KD_RST;
    integ_q    = '{0, 0};
    prev_err_q = '{0, 0};
    setpoint_q = '0;

    rst_n                     <= 1'b0;
    cfg_we                    <= 1'b0;
    cfg_idx                   <= REG_POS_KP;
    cfg_data                  <= '0;
    in_ch.valid               <= 1'b0;
    in_ch.position_target     <= '0;
    in_ch.position            <= '0;
    in_ch.speed               <= '0;
    in_ch.direct_speed_target <= '0;
    in_ch.load_speed_target   <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed ticks at reset gains
    for (int i = 0; i < DIR_N; i++) begin
      send_tick(dir_rows[i].stim, dir_rows[i].typed, dir_rows[i].want);
    end

    // Random phases, each under its own gain setting
    for (int ph = 0; ph < PHASES; ph++) begin
      wait_results_done();
      for (int k = 0; k < GAIN_COUNT; k++) begin
        case (ph)
          0:       new_gain[k] = '1;
          1:       new_gain[k] = '0;
          3:       new_gain[k] = GAIN_W'($urandom());
          default: new_gain[k] = '0;
        endcase
      end
      if (ph == 2 || ph == 5) begin
        new_gain[REG_POS_KP] = GAIN_W'($urandom_range(0, 4 << FRAC_BITS));
        new_gain[REG_POS_KI] = GAIN_W'($urandom_range(0, 1 << (FRAC_BITS - 2)));
        new_gain[REG_POS_KD] = GAIN_W'($urandom_range(0, 2 << FRAC_BITS));
        new_gain[REG_SPD_KP] = GAIN_W'($urandom_range(0, 4 << FRAC_BITS));
        new_gain[REG_SPD_KI] = GAIN_W'($urandom_range(0, 1 << (FRAC_BITS - 2)));
        new_gain[REG_SPD_KD] = GAIN_W'($urandom_range(0, 2 << FRAC_BITS));
      end
      if (ph == 4) begin
        new_gain[REG_POS_KP] = POS_KP_RST;
        new_gain[REG_POS_KI] = POS_KI_RST;
        new_gain[REG_POS_KD] = POS_KD_RST;
        new_gain[REG_SPD_KP] = SPD_KP_RST;
        new_gain[REG_SPD_KI] = SPD_KI_RST;
        new_gain[REG_SPD_KD] = SPD_KD_RST;
      end
      for (int k = 0; k < GAIN_COUNT; k++) write_reg(REG_IDX_W'(k), new_gain[k]);
      // Writes past the last register must leave every gain alone
      if (ph == 2) begin
        write_reg(REG_SPARE_LO, GAIN_W'($urandom()));
        write_reg(REG_SPARE_HI, GAIN_W'($urandom()));
      end
      cfg_we <= 1'b0;

      for (int n = 0; n < phase_items[ph]; n++) begin
        kind = int'($urandom_range(0, 99));
        t.target   = '0;
        t.position = POS_W'($urandom());
        t.speed    = '0;
        t.direct   = POS_W'($urandom());
        t.load     = 1'($urandom_range(0, 1));
        if (kind < 40) begin
          // Position loop tracking a nearby target
          v = int'($urandom_range(0, 2000000)) - 1000000;
          if (v == 0) v = 1;
          delta      = int'($urandom_range(0, 400)) - 200;
          t.target   = v;
          t.position = v - delta;
          t.speed    = SPEED_W'(int'($urandom_range(0, 4000)) - 2000);
        end else if (kind < 70) begin
          // Speed loop alone, speed close to the setpoint
          v        = int'($urandom_range(0, 6000)) - 3000;
          t.direct = v;
          t.load   = ($urandom_range(0, 2) == 0);
          ref_sp   = t.load ? longint'(t.direct) : longint'(setpoint_q);
          s        = ref_sp + int'($urandom_range(0, 500)) - 250;
          if (s > longint'(S16_MAX)) s = S16_MAX;
          if (s < longint'(S16_MIN)) s = S16_MIN;
          t.speed = SPEED_W'(s);
        end else if (kind < 78) begin
          // Errors just inside, on and just outside the band
          delta = 99 + int'($urandom_range(0, 2));
          if ($urandom_range(0, 1) == 1) delta = -delta;
          v = int'($urandom_range(1000, 1000000));
          if ($urandom_range(0, 1) == 1) begin
            t.position = v;
            t.target   = v + delta;
          end else begin
            t.load     = 1'b1;
            t.speed    = SPEED_W'(int'($urandom_range(0, 2000)) - 1000);
            t.direct   = POS_W'(t.speed) + delta;
          end
        end else if (kind < 90) begin
          // Unconstrained fields
          t.target = POS_W'($urandom());
          t.speed  = SPEED_W'($urandom());
        end else begin
          t.load  = 1'b0;
          t.speed = SPEED_W'($urandom());
        end
        send_tick(t, 1'b0, none);
        if ($urandom_range(0, 99) == 0) wait_results_done();
      end
    end

    wait_results_done();
    repeat (DRAIN_TAIL) @(posedge clk);
    if (predicted_q.size() != 0)
      report_mismatch("results never delivered", predicted_q.size(), 0);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
